[hdl/tcc_pkg.sv]
// Package with the shared constants and types of the text console cursor engine.
`default_nettype none
package tcc_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int POS_W  = 8;
  localparam int CELL_W = 16;
  localparam int REQ_W  = 2;

  localparam int IN_FIELDS_W = REQ_W + CHAR_W + ATTR_W + 2 * POS_W;
  localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_MUL,
    ST_MEM,
    ST_SADDR,
    ST_SCROLL,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

[hdl/text_console_cursor_engine_unit.sv]
// Top level of the text console cursor engine: cell memory, cursor and sequencer.
//
// Items arrive on the in_ stream channel and each one yields exactly one result
// transaction on the out_ channel. The attribute register is written on the cfg_
// channel, which is always ready.
// The cell memory holds ROWS x COLUMNS cells in a rotating row order: a scroll
// moves the base row forward and blanks one physical row instead of copying.
// A put, write or read passes from acceptance to the result register through
// the address path: row rotation, one shared multiplier for the cell address,
// then the memory access; a new item is accepted only once the last one is done.
// A scroll then blanks the new bottom row, and a clear blanks the whole memory
// before its result appears.
// in_tready is high only while the sequencer is idle, so one item is in work
// at a time; the next item is accepted while a result still waits in the
// output register.
// After reset the block blanks the whole memory and keeps in_tready low
// meanwhile; configuration writes are taken during that time.
// When the receiver stalls, the result stays in the output register and a
// following item stops at its final step until the register is free.
`default_nettype none
module text_console_cursor_engine_unit
  import tcc_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int CW     = $clog2(COLUMNS),
  localparam int RW     = $clog2(ROWS),
  localparam int OUT_W  = ((CELL_W + RW + CW + 1 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [ATTR_W-1:0] cfg_data,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // req_type, char_code, entry_attribute, pos_x, pos_y
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // read_data, cursor_row, cursor_col, scrolled
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data_r;

  state_t state_r, state_nxt;

  logic [ATTR_W-1:0] attr_r;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     base_r;
  logic [RW-1:0]     tgt_row_r, tgt_row_nxt;
  logic [CW-1:0]     tgt_col_r, tgt_col_nxt;
  logic [RW-1:0]     phys_r;
  logic [AW-1:0]     addr_r;
  logic [CW-1:0]     cnt_r;
  logic              wr_en_r, wr_en_nxt;
  logic [CELL_W-1:0] wr_data_r, wr_data_nxt;
  logic              rd_en_r, rd_en_nxt;
  logic              scroll_r, scroll_nxt;
  logic              clr_item_r;

  logic              out_valid_r;
  logic [CELL_W-1:0] out_rdata_r;
  logic [RW-1:0]     out_row_r;
  logic [CW-1:0]     out_col_r;
  logic              out_scr_r;

  logic [REQ_W-1:0]  f_req;
  logic [CHAR_W-1:0] f_char;
  logic [ATTR_W-1:0] f_attr;
  logic [POS_W-1:0]  f_x;
  logic [POS_W-1:0]  f_y;
  logic              in_acc;
  logic              in_range;
  logic              last_row;
  logic              last_col;
  logic              slot_free;
  logic              clear_end;
  logic              scroll_end;

  logic              mem_we;
  logic [CELL_W-1:0] mem_wdata;
  logic [RW-1:0]     wrap_a;
  logic [RW-1:0]     wrap_b;
  logic [RW:0]       wrap_sum;
  logic [RW-1:0]     wrap_res;
  logic [RW-1:0]     mul_row;
  logic [CW-1:0]     mul_col;
  logic [AW-1:0]     mul_res;

  assign f_req  = in_tdata[REQ_W-1:0];
  assign f_char = in_tdata[REQ_W +: CHAR_W];
  assign f_attr = in_tdata[REQ_W + CHAR_W +: ATTR_W];
  assign f_x    = in_tdata[REQ_W + CHAR_W + ATTR_W +: POS_W];
  assign f_y    = in_tdata[REQ_W + CHAR_W + ATTR_W + POS_W +: POS_W];

  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign in_range   = (f_x < POS_W'(COLUMNS)) && (f_y < POS_W'(ROWS));
  assign last_row   = (row_r == RW'(ROWS - 1));
  assign last_col   = (col_r == CW'(COLUMNS - 1));
  assign slot_free  = !out_valid_r || out_tready;
  assign clear_end  = (addr_r == AW'(CELLS - 1));
  assign scroll_end = (cnt_r == CW'(COLUMNS - 1));

  // Shared row rotation adder and shared address multiplier.
  assign wrap_sum = {1'b0, wrap_a} + {1'b0, wrap_b};
  assign wrap_res = (wrap_sum >= (RW + 1)'(ROWS)) ? RW'(wrap_sum - (RW + 1)'(ROWS))
                                                  : RW'(wrap_sum);
  assign mul_res  = AW'(mul_row) * AW'(COLUMNS) + AW'(mul_col);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clear_end) state_nxt = clr_item_r ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = (f_req == REQ_CLEAR) ? ST_CLEAR : ST_ADDR;
      end
      ST_ADDR:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_MEM;
      ST_MEM:   state_nxt = scroll_r ? ST_SADDR : ST_DONE;
      ST_SADDR: state_nxt = ST_SCROLL;
      ST_SCROLL: begin
        if (scroll_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = BLANK_CELL;
    wrap_a    = tgt_row_r;
    wrap_b    = base_r;
    mul_row   = phys_r;
    mul_col   = tgt_col_r;
    unique case (state_r)
      ST_CLEAR:  mem_we = 1'b1;
      ST_IDLE:   in_tready = 1'b1;
      ST_MEM: begin
        mem_we    = wr_en_r;
        mem_wdata = wr_data_r;
      end
      ST_SADDR: begin
        mul_row = base_r;
        mul_col = '0;
      end
      ST_SCROLL: begin
        mem_we = 1'b1;
        wrap_a = RW'(1);
      end
      default: ;
    endcase
  end

  // Decode of an item at acceptance: target cell, cursor after the item, scroll.
  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    tgt_row_nxt = row_r;
    tgt_col_nxt = col_r;
    wr_en_nxt   = 1'b0;
    wr_data_nxt = BLANK_CELL;
    rd_en_nxt   = 1'b0;
    scroll_nxt  = 1'b0;
    unique case (f_req)
      REQ_PUT: begin
        if (f_char == CH_NEWLINE) begin
          col_nxt    = '0;
          scroll_nxt = last_row;
          row_nxt    = last_row ? row_r : row_r + RW'(1);
        end else if (f_char == CH_BACKSPACE) begin
          if (col_r != '0) begin
            col_nxt = col_r - CW'(1);
          end else if (row_r != '0) begin
            row_nxt = row_r - RW'(1);
            col_nxt = CW'(COLUMNS - 1);
          end
          tgt_row_nxt = row_nxt;
          tgt_col_nxt = col_nxt;
          wr_en_nxt   = 1'b1;
        end else begin
          wr_en_nxt   = 1'b1;
          wr_data_nxt = {attr_r, f_char};
          if (last_col) begin
            col_nxt    = '0;
            scroll_nxt = last_row;
            row_nxt    = last_row ? row_r : row_r + RW'(1);
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end
      REQ_WRITE: begin
        tgt_row_nxt = RW'(f_y);
        tgt_col_nxt = CW'(f_x);
        wr_en_nxt   = in_range;
        wr_data_nxt = {f_attr, f_char};
      end
      REQ_CLEAR: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      default: begin
        tgt_row_nxt = RW'(f_y);
        tgt_col_nxt = CW'(f_x);
        rd_en_nxt   = in_range;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_r] <= mem_wdata;
    rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      attr_r      <= ATTR_RESET;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      addr_r      <= '0;
      cnt_r       <= '0;
      clr_item_r  <= 1'b0;
      wr_en_r     <= 1'b0;
      rd_en_r     <= 1'b0;
      scroll_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) attr_r <= cfg_data;
      if (in_acc) begin
        row_r      <= row_nxt;
        col_r      <= col_nxt;
        wr_en_r    <= wr_en_nxt;
        rd_en_r    <= rd_en_nxt;
        scroll_r   <= scroll_nxt;
        clr_item_r <= (f_req == REQ_CLEAR);
        if (f_req == REQ_CLEAR) begin
          base_r <= '0;
          addr_r <= '0;
        end
      end
      case (state_r)
        ST_CLEAR:  addr_r <= addr_r + AW'(1);
        ST_MUL:    addr_r <= mul_res;
        ST_SADDR: begin
          addr_r <= mul_res;
          cnt_r  <= '0;
        end
        ST_SCROLL: begin
          addr_r <= addr_r + AW'(1);
          cnt_r  <= cnt_r + CW'(1);
          if (scroll_end) base_r <= wrap_res;
        end
        default: ;
      endcase
      if (state_r == ST_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_row_r <= tgt_row_nxt;
      tgt_col_r <= tgt_col_nxt;
      wr_data_r <= wr_data_nxt;
    end
    if (state_r == ST_ADDR) phys_r <= wrap_res;
    if (state_r == ST_DONE && slot_free) begin
      out_rdata_r <= rd_en_r ? rd_data_r : '0;
      out_row_r   <= row_r;
      out_col_r   <= col_r;
      out_scr_r   <= scroll_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_scr_r, out_col_r, out_row_r, out_rdata_r});

endmodule
`default_nettype wire

[hdl/tcc_checker.sv]
// Port-level checker for the text console cursor engine and its bind statement.
`default_nettype none
module tcc_checker
  import tcc_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int CW     = $clog2(COLUMNS),
  localparam int RW     = $clog2(ROWS),
  localparam int OUT_W  = ((CELL_W + RW + CW + 1 + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  logic [RW-1:0] row_w;
  logic [CW-1:0] col_w;

  assign row_w = out_tdata[CELL_W +: RW];
  assign col_w = out_tdata[CELL_W + RW +: CW];

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid after reset.");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed.");

  a_one_item_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Second item accepted while one is in work.");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (row_w <= RW'(ROWS - 1)) && (col_w <= CW'(COLUMNS - 1)))
    else $error("Cursor outside the screen.");

endmodule

bind text_console_cursor_engine_unit tcc_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire

[sim/text_console_cursor_engine_unit_tb.sv]
// Self-checking testbench for the text console cursor engine: directed steps, then random traffic.
`timescale 1ns / 1ps
module text_console_cursor_engine_unit_tb;
  import tcc_pkg::*;

  localparam int COLS        = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  localparam int CELLS       = COLS * ROWS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int COL_W       = $clog2(COLS);
  localparam int OUT_BITS    = ((CELL_W + ROW_W + COL_W + 1 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 420;

  typedef struct packed {
    req_t             req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] entry_attribute;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
  } console_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] read_data;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
  } console_result_t;

  typedef struct packed {
    console_req_t    item;
    logic [7:0]      count;
    logic            typed;
    console_result_t result;
  } console_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ATTR_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;

  console_result_t pending_console_results[$];
  logic [CELL_W-1:0] screen_model [CELLS];
  int cur_row;
  int cur_col;
  logic [ATTR_W-1:0] attr_model = ATTR_RESET;

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int text_run_left = 0;

  console_step_t directed_steps [31];

  text_console_cursor_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
  endfunction

  function automatic logic advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic put_console_char(logic [CHAR_W-1:0] ch);
    if (ch == CH_NEWLINE) return advance_row();
    if (ch == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_row > 0) begin
        cur_row--;
        cur_col = COLS - 1;
      end
      screen_model[cur_row * COLS + cur_col] = BLANK_CELL;
      return 1'b0;
    end
    screen_model[cur_row * COLS + cur_col] = {attr_model, ch};
    cur_col++;
    if (cur_col >= COLS) return advance_row();
    return 1'b0;
  endfunction

  function automatic console_result_t apply_console_request(console_req_t r);
    console_result_t res;
    logic in_screen;
    int idx;
    res = '0;
    in_screen = (int'(r.pos_x) < COLS) && (int'(r.pos_y) < ROWS);
    idx = int'(r.pos_y) * COLS + int'(r.pos_x);
    case (r.req_type)
      REQ_PUT: begin
        res.scrolled = put_console_char(r.char_code);
      end
      REQ_WRITE: begin
        if (in_screen) screen_model[idx] = {r.entry_attribute, r.char_code};
      end
      REQ_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        if (in_screen) res.read_data = screen_model[idx];
      end
    endcase
    res.cursor_row = cur_row[ROW_W-1:0];
    res.cursor_col = cur_col[COL_W-1:0];
    return res;
  endfunction

  function automatic console_req_t next_random_request();
    console_req_t r;
    int pick;
    r.req_type        = REQ_PUT;
    r.char_code       = CHAR_W'($urandom_range(255));
    r.entry_attribute = ATTR_W'($urandom_range(255));
    r.pos_x           = POS_W'($urandom_range(255));
    r.pos_y           = POS_W'($urandom_range(255));
    pick = $urandom_range(999);
    if (text_run_left == 0 && pick < 6) text_run_left = $urandom_range(170, 60);
    if (text_run_left > 0) begin
      text_run_left--;
      if (r.char_code == CH_NEWLINE || r.char_code == CH_BACKSPACE) r.char_code = 8'h2e;
      return r;
    end
    if (pick < 10) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 400) begin
      if (pick < 200) begin
        r.req_type = REQ_WRITE;
      end else begin
        r.req_type = REQ_READ;
      end
      if ($urandom_range(9) != 0) begin
        r.pos_x = POS_W'($urandom_range(COLS - 1));
        r.pos_y = POS_W'($urandom_range(ROWS - 1));
      end
    end else if (pick < 520) begin
      r.char_code = CH_NEWLINE;
    end else if (pick < 600) begin
      r.char_code = CH_BACKSPACE;
    end
    return r;
  endfunction

  task automatic offer_request(console_req_t r, logic typed, console_result_t typed_result);
    console_result_t predicted;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - IN_FIELDS_W){1'b0}}, r.pos_y, r.pos_x, r.entry_attribute,
                  r.char_code, r.req_type};
    do @(posedge clk); while (!in_tready);
    predicted = apply_console_request(r);
    pending_console_results.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_console_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    attr_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(int items);
    for (int n = 0; n < items; n++) offer_request(next_random_request(), 1'b0, '0);
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    console_result_t got;
    console_result_t want;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.read_data  = out_tdata[CELL_W-1:0];
        got.cursor_row = out_tdata[CELL_W +: ROW_W];
        got.cursor_col = out_tdata[CELL_W + ROW_W +: COL_W];
        got.scrolled   = out_tdata[CELL_W + ROW_W + COL_W];
        if (pending_console_results.size() == 0) begin
          $error("result transaction with nothing expected: %h", out_tdata);
          error_count++;
        end else begin
          want = pending_console_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data expected %h got %h", want.read_data, got.read_data);
            error_count++;
          end
          if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row expected %0d got %0d", want.cursor_row, got.cursor_row);
            error_count++;
          end
          if (got.cursor_col !== want.cursor_col) begin
            $error("cursor_col expected %0d got %0d", want.cursor_col, got.cursor_col);
            error_count++;
          end
          if (got.scrolled !== want.scrolled) begin
            $error("scrolled expected %0d got %0d", want.scrolled, got.scrolled);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    blank_screen();
    cur_row = 0;
    cur_col = 0;
    directed_steps = '{
      '{'{REQ_READ,  8'h00, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0720, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd79,  8'd24},  8'd1,  1'b1, '{16'h0720, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd80,  8'd0},   8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd0,   8'd25},  8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'hff, 8'hff, 8'd255, 8'd255}, 8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_PUT,   8'h41, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd0,  7'd1,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0741, 5'd0,  7'd1,  1'b0}},
      '{'{REQ_PUT,   8'h08, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_PUT,   8'h08, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0720, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_WRITE, 8'hff, 8'hff, 8'd79,  8'd24},  8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd79,  8'd24},  8'd1,  1'b1, '{16'hffff, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_WRITE, 8'h00, 8'h00, 8'd80,  8'd24},  8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_WRITE, 8'h55, 8'haa, 8'd0,   8'd25},  8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd0,   8'd24},  8'd1,  1'b1, '{16'h0720, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_WRITE, 8'h00, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_PUT,   8'h0a, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd1,  7'd0,  1'b0}},
      '{'{REQ_PUT,   8'h08, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd0,  7'd79, 1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd79,  8'd0},   8'd1,  1'b1, '{16'h0720, 5'd0,  7'd79, 1'b0}},
      '{'{REQ_PUT,   8'hff, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd1,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd79,  8'd0},   8'd1,  1'b1, '{16'h07ff, 5'd1,  7'd0,  1'b0}},
      '{'{REQ_PUT,   8'h00, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd1,  7'd1,  1'b0}},
      '{'{REQ_PUT,   8'h0a, 8'h00, 8'd0,   8'd0},   8'd22, 1'b0, '0},
      '{'{REQ_PUT,   8'h0a, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd24, 7'd0,  1'b0}},
      '{'{REQ_PUT,   8'h0a, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd24, 7'd0,  1'b1}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd79,  8'd23},  8'd1,  1'b1, '{16'hffff, 5'd24, 7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0700, 5'd24, 7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd79,  8'd24},  8'd1,  1'b1, '{16'h0720, 5'd24, 7'd0,  1'b0}},
      '{'{REQ_CLEAR, 8'h00, 8'h00, 8'd0,   8'd0},   8'd1,  1'b1, '{16'h0000, 5'd0,  7'd0,  1'b0}},
      '{'{REQ_READ,  8'h00, 8'h00, 8'd79,  8'd24},  8'd1,  1'b1, '{16'h0720, 5'd0,  7'd0,  1'b0}}
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 24;
    recv_idle_pct = 53;
    foreach (directed_steps[i]) begin
      for (int k = 0; k < directed_steps[i].count; k++) begin
        offer_request(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].result);
      end
    end
    in_tvalid <= 1'b0;
    wait_drained();

    write_attribute(8'hff);
    run_random_phase(PHASE_ITEMS);

    send_idle_pct = 53;
    recv_idle_pct = 24;
    write_attribute(8'h00);
    run_random_phase(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_attribute(ATTR_W'($urandom_range(254, 1)));
    hold_asked++;
    run_random_phase(PHASE_ITEMS - 10);

    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
